FILE: rtl/u8sd_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Shared codes, byte constants and the lead byte length decoder.
// ----------------------------------------------------------------------------
package u8sd_pkg;

   // Default width of the per-string character counter.
   localparam int COUNT_WIDTH_DEF = 32;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_IGNORE_ERRORS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SKIP_BOM      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNT_ONLY    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUT_CAPACITY  = 2'd3;

   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_DATA_W-1:0] OUT_CAPACITY_RST = 16'hffff;

   // Result kinds.
   localparam logic [1:0] KIND_CHAR = 2'd0;
   localparam logic [1:0] KIND_DONE = 2'd1;
   localparam logic [1:0] KIND_FAIL = 2'd2;

   // Bytes that are never valid as a lead.
   localparam logic [7:0] BYTE_C0 = 8'hc0;
   localparam logic [7:0] BYTE_C1 = 8'hc1;
   localparam logic [7:0] BYTE_F5 = 8'hf5;
   localparam logic [7:0] BYTE_FF = 8'hff;

   // Code point limits.
   localparam logic [30:0] SURROGATE_LO = 31'h0000d800;
   localparam logic [30:0] SURROGATE_HI = 31'h0000dfff;
   localparam logic [30:0] BOM_CHAR     = 31'h0000feff;

   // Buffer of one sequence.
   localparam int PEND_DEPTH = 6;
   localparam int PEND_CNT_W = 3;

   // Sequence length from the lead byte; zero marks a bad lead.
   function automatic logic [PEND_CNT_W-1:0] seq_len(input logic [7:0] b);
      logic [PEND_CNT_W-1:0] n;
      n = 3'd0;
      if (b[7] == 1'b0)             n = 3'd1;
      else if (b[7:5] == 3'b110)    n = 3'd2;
      else if (b[7:4] == 4'b1110)   n = 3'd3;
      else if (b[7:3] == 5'b11110)  n = 3'd4;
      else if (b[7:2] == 6'b111110) n = 3'd5;
      else if (b[7:1] == 7'b1111110) n = 3'd6;
      return n;
   endfunction

endpackage

FILE: rtl/utf8_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder unit
// Decodes a UTF-8 byte stream into code points, with per-string counts.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake            Contents
// req_      in         tvalid/tready        one byte, tlast ends a string
// rsp_      out        tvalid/tready        one result, tlast ends a byte's results
// csr_      in         wen only             register index and write data
//
// A byte is taken while idle, then one decode step per cycle runs on the
// shared sequence unit until the buffer holds no complete sequence. Each
// further step (replay after a dropped lead, the string's closing result)
// adds to a byte's work, and a flush step follows when two results must
// leave in the same step. The output register stalls the sequencer while a
// result waits. Reset is synchronous and clears all control state.
//
module utf8_stream_decoder_unit #(
   parameter int COUNT_WIDTH = u8sd_pkg::COUNT_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // Input items
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,   // [7:0] data_byte
   input  logic                               req_tlast,   // last_byte
   // Result items
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [63:0]                        rsp_tdata,   // [30:0] code_point,
                                                           // [62:31] char_count
   output logic [1:0]                         rsp_tuser,   // [1:0] kind
   output logic                               rsp_tlast,   // last_result
   // Configuration writes
   input  logic                               csr_wen,
   input  logic [u8sd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [u8sd_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import u8sd_pkg::*;

   localparam int CMP_W = (COUNT_WIDTH > CSR_DATA_W) ? COUNT_WIDTH : CSR_DATA_W;
   localparam int PEND_W = 8 * PEND_DEPTH;

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_RUN   = 3'b010,
      S_FLUSH = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // Sequence buffer and string state.
   logic [PEND_W-1:0]      pend_ff, pend_in;
   logic [PEND_CNT_W-1:0]  pend_cnt_ff, pend_cnt_in;
   logic [COUNT_WIDTH-1:0] total_ff, total_in;
   logic                   failed_ff, failed_in;
   logic                   last_ff, last_in;

   // Configuration.
   logic                   ignore_ff, ignore_in;
   logic                   skip_bom_ff, skip_bom_in;
   logic                   count_only_ff, count_only_in;
   logic [CSR_DATA_W-1:0]  cap_ff, cap_in;

   // Held result, waiting to learn whether it is the byte's last one.
   logic                   hold_valid_ff, hold_valid_in;
   logic [1:0]             hold_kind_ff, hold_kind_in;
   logic [30:0]            hold_cp_ff, hold_cp_in;
   logic [COUNT_WIDTH-1:0] hold_cnt_ff, hold_cnt_in;

   // Output register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_kind_ff, rsp_kind_in;
   logic [30:0]            rsp_cp_ff, rsp_cp_in;
   logic [COUNT_WIDTH-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic                   rsp_last_ff, rsp_last_in;

   // Decode step signals.
   logic [7:0]             lead;
   logic [PEND_CNT_W-1:0]  seq_n;
   logic [PEND_CNT_W-1:0]  avail;
   logic                   cont_bad;
   logic                   forbidden;
   logic                   incomplete;
   logic [30:0]            cp;
   logic [COUNT_WIDTH-1:0] total_inc;
   logic                   cap_full;
   logic                   is_surrogate;
   logic                   out_free;
   logic [PEND_CNT_W-1:0]  wr_idx;

   // Step outcome.
   logic                   new_res;
   logic [1:0]             new_kind;
   logic [30:0]            new_cp;
   logic [COUNT_WIDTH-1:0] new_cnt;
   logic                   step_done;
   logic                   drop_en;
   logic [PEND_CNT_W-1:0]  drop_k;

   // The shared sequence unit: examines the buffer front in one step.
   always_comb begin
      lead      = pend_ff[7:0];
      seq_n     = seq_len(lead);
      avail     = (seq_n < pend_cnt_ff) ? seq_n : pend_cnt_ff;
      forbidden = (lead == BYTE_C0) || (lead == BYTE_C1) ||
                  (lead == BYTE_F5) || (lead == BYTE_FF);
      cont_bad  = 1'b0;
      for (int i = 1; i < PEND_DEPTH; i++) begin
         if ((PEND_CNT_W'(i) < avail) && (pend_ff[8*i+6 +: 2] != 2'b10)) begin
            cont_bad = 1'b1;
         end
      end
      incomplete = !cont_bad && (pend_cnt_ff < seq_n);
   end

   // Code point assembly from the buffered bytes.
   always_comb begin
      case (seq_n)
         3'd1: cp = 31'(lead[6:0]);
         3'd2: cp = 31'({lead[4:0], pend_ff[8 +: 6]});
         3'd3: cp = 31'({lead[3:0], pend_ff[8 +: 6], pend_ff[16 +: 6]});
         3'd4: cp = 31'({lead[2:0], pend_ff[8 +: 6], pend_ff[16 +: 6],
                         pend_ff[24 +: 6]});
         3'd5: cp = 31'({lead[1:0], pend_ff[8 +: 6], pend_ff[16 +: 6],
                         pend_ff[24 +: 6], pend_ff[32 +: 6]});
         3'd6: cp = {lead[0], pend_ff[8 +: 6], pend_ff[16 +: 6],
                     pend_ff[24 +: 6], pend_ff[32 +: 6], pend_ff[40 +: 6]};
         default: cp = '0;
      endcase
      is_surrogate = (cp >= SURROGATE_LO) && (cp <= SURROGATE_HI);
      total_inc    = (&total_ff) ? total_ff : total_ff + 1'b1;
      cap_full     = CMP_W'(total_ff) >= CMP_W'(cap_ff);
   end

   // Step decision for the current buffer contents.
   always_comb begin
      new_res   = 1'b0;
      new_kind  = KIND_CHAR;
      new_cp    = '0;
      new_cnt   = '0;
      step_done = 1'b0;
      drop_en   = 1'b0;
      drop_k    = seq_n;
      if (pend_cnt_ff == '0 || (seq_n != '0 && !(!ignore_ff && forbidden) &&
                                incomplete && !last_ff)) begin
         // Nothing complete is left: close the string or wait for bytes.
         step_done = 1'b1;
         if (last_ff) begin
            new_res  = 1'b1;
            new_kind = KIND_DONE;
            new_cnt  = total_ff;
         end
      end else if ((!ignore_ff && forbidden) ||
                   (!ignore_ff && (seq_n == '0 || cont_bad || incomplete))) begin
         step_done = 1'b1;
         new_res   = 1'b1;
         new_kind  = KIND_FAIL;
      end else if (seq_n == '0 || cont_bad || incomplete) begin
         // Ignore mode: drop the lead and replay what follows.
         drop_en = 1'b1;
         drop_k  = 3'd1;
      end else begin
         drop_en = 1'b1;
         if (count_only_ff) begin
            // Counted only.
         end else if (cap_full || (is_surrogate && !ignore_ff)) begin
            drop_en   = 1'b0;
            step_done = 1'b1;
            new_res   = 1'b1;
            new_kind  = KIND_FAIL;
         end else if (!is_surrogate && !(cp == BOM_CHAR && skip_bom_ff)) begin
            new_res = 1'b1;
            new_cp  = cp;
            new_cnt = total_inc;
         end
      end
      // A step that empties the buffer mid-string ends the byte's work.
      if (drop_en && !last_ff && (drop_k >= pend_cnt_ff)) begin
         step_done = 1'b1;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign wr_idx   = (pend_cnt_ff >= PEND_CNT_W'(PEND_DEPTH)) ? '0 : pend_cnt_ff;

   // Sequencer and register next values.
   always_comb begin
      state_in      = state_ff;
      pend_in       = pend_ff;
      pend_cnt_in   = pend_cnt_ff;
      total_in      = total_ff;
      failed_in     = failed_ff;
      last_in       = last_ff;
      ignore_in     = ignore_ff;
      skip_bom_in   = skip_bom_ff;
      count_only_in = count_only_ff;
      cap_in        = cap_ff;
      hold_valid_in = hold_valid_ff;
      hold_kind_in  = hold_kind_ff;
      hold_cp_in    = hold_cp_ff;
      hold_cnt_in   = hold_cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_cp_in     = rsp_cp_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_last_in   = rsp_last_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (failed_ff) begin
                  // Discard the rest of a failed string.
                  if (req_tlast) begin
                     failed_in   = 1'b0;
                     total_in    = '0;
                     pend_cnt_in = '0;
                  end
               end else begin
                  pend_in[{wr_idx, 3'b000} +: 8] = req_tdata;
                  pend_cnt_in = wr_idx + 1'b1;
                  last_in     = req_tlast;
                  state_in    = S_RUN;
               end
            end
         end
         S_RUN: begin
            if (out_free) begin
               // Buffer and counter update of this step.
               if (drop_en) begin
                  if (drop_k >= pend_cnt_ff) begin
                     pend_cnt_in = '0;
                  end else begin
                     pend_in     = pend_ff >> {drop_k, 3'b000};
                     pend_cnt_in = pend_cnt_ff - drop_k;
                  end
                  if (seq_n != '0 && !cont_bad && !incomplete &&
                      (count_only_ff || new_res)) begin
                     total_in = total_inc;
                  end
               end
               if (step_done && (new_kind == KIND_FAIL || new_kind == KIND_DONE) &&
                   new_res) begin
                  pend_cnt_in = '0;
                  total_in    = '0;
                  failed_in   = (new_kind == KIND_FAIL) && !last_ff;
               end
               // Result routing through the hold stage.
               if (step_done) begin
                  state_in = S_IDLE;
                  if (new_res && hold_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = hold_kind_ff;
                     rsp_cp_in    = hold_cp_ff;
                     rsp_cnt_in   = hold_cnt_ff;
                     rsp_last_in  = 1'b0;
                     hold_kind_in = new_kind;
                     hold_cp_in   = new_cp;
                     hold_cnt_in  = new_cnt;
                     state_in     = S_FLUSH;
                  end else if (new_res) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = new_kind;
                     rsp_cp_in    = new_cp;
                     rsp_cnt_in   = new_cnt;
                     rsp_last_in  = 1'b1;
                  end else if (hold_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_kind_in   = hold_kind_ff;
                     rsp_cp_in     = hold_cp_ff;
                     rsp_cnt_in    = hold_cnt_ff;
                     rsp_last_in   = 1'b1;
                     hold_valid_in = 1'b0;
                  end
               end else if (new_res) begin
                  if (hold_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = hold_kind_ff;
                     rsp_cp_in    = hold_cp_ff;
                     rsp_cnt_in   = hold_cnt_ff;
                     rsp_last_in  = 1'b0;
                  end
                  hold_valid_in = 1'b1;
                  hold_kind_in  = new_kind;
                  hold_cp_in    = new_cp;
                  hold_cnt_in   = new_cnt;
               end
            end
         end
         S_FLUSH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = hold_kind_ff;
               rsp_cp_in     = hold_cp_ff;
               rsp_cnt_in    = hold_cnt_ff;
               rsp_last_in   = 1'b1;
               hold_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Configuration writes.
      if (csr_wen) begin
         unique case (csr_index)
            CSR_IGNORE_ERRORS: ignore_in     = csr_wdata[0];
            CSR_SKIP_BOM:      skip_bom_in   = csr_wdata[0];
            CSR_COUNT_ONLY:    count_only_in = csr_wdata[0];
            CSR_OUT_CAPACITY:  cap_in        = csr_wdata;
            default:           cap_in        = cap_ff;
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_cnt_ff   <= '0;
         total_ff      <= '0;
         failed_ff     <= 1'b0;
         last_ff       <= 1'b0;
         ignore_ff     <= 1'b0;
         skip_bom_ff   <= 1'b0;
         count_only_ff <= 1'b0;
         cap_ff        <= OUT_CAPACITY_RST;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_cnt_ff   <= pend_cnt_in;
         total_ff      <= total_in;
         failed_ff     <= failed_in;
         last_ff       <= last_in;
         ignore_ff     <= ignore_in;
         skip_bom_ff   <= skip_bom_in;
         count_only_ff <= count_only_in;
         cap_ff        <= cap_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pend_ff      <= pend_in;
      hold_kind_ff <= hold_kind_in;
      hold_cp_ff   <= hold_cp_in;
      hold_cnt_ff  <= hold_cnt_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_cp_ff    <= rsp_cp_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {1'b0, 32'(rsp_cnt_ff), rsp_cp_ff};

   // No result is held back once the sequencer has gone idle.
   a_idle_no_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !hold_valid_ff)
      else $error("result left in hold stage while idle");

   // A failed string keeps no buffered bytes and no count.
   a_failed_clear: assert property (@(posedge clock) disable iff (reset)
      failed_ff |-> (pend_cnt_ff == '0 && total_ff == '0))
      else $error("failed string still holds state");

   // A failure result carries a zero count and closes the byte's results.
   a_fail_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_FAIL) |-> (rsp_tdata[62:31] == '0 && rsp_tlast))
      else $error("failure result malformed");

endmodule
